/* rtl/rdc_pkg.sv */
// Shared types and constants of the register datagram codec.
package rdc_pkg;

	localparam int unsigned RESP_LEN_DEF = 8;
	localparam int unsigned FRAME_LEN    = 8;
	localparam int unsigned WR_LEN       = 8;
	localparam int unsigned RD_LEN       = 4;

	localparam logic [7:0] CRC_POLY  = 8'h07;
	localparam logic [7:0] WR_FLAG   = 8'h80;
	localparam logic [7:0] RESP_MARK = 8'hFF;
	localparam logic [7:0] LSB_MASK  = 8'h01;

	localparam logic [7:0] NODE_ADDR_RST = 8'h00;
	localparam logic [7:0] SYNC_RST      = 8'h05;

	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_ADDR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC      = 1'd1;

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_RESP  = 2'd2;

	localparam logic KIND_BYTE    = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_SHORT    = 2'd1;
	localparam logic [1:0] STAT_NO_FRAME = 2'd2;
	localparam logic [1:0] STAT_CRC_BAD  = 2'd3;

	// command word from the sequencer to the bit-serial CRC unit
	typedef struct packed {
		logic       clr;
		logic       ld;
		logic [7:0] din;
	} crc_cmd_t;

endpackage

/* rtl/register_datagram_codec_unit.sv */
// Register datagram codec: request framer and response checker with serial CRC-8.
//
// Input words (s_axis) carry a request or one received response byte; tuser
// selects which. A write request yields eight output words (sync, address,
// register | 0x80, four data bytes MSB first, CRC) and a read request four;
// tlast marks the CRC word. Each byte before the CRC passes the bit-serial CRC
// unit, and the next byte is sent only once the unit is done shifting.
// Response bytes are stored in a small RAM and accepted back to back; the byte
// with tlast starts the check, which scans the stored bytes position by
// position (ST_SCAN_RD, then ST_SCAN_CHK) and then runs seven bytes through
// the CRC unit, waiting for it after each, giving one verdict word (tuser high).
// A short response (fewer than eight bytes) goes to its verdict with no scan.
// One item is worked at a time; s_axis_tready is high only between items.
// A result sits in the output register until taken; the sequencer waits on
// it when the receiver stalls and the next item may already be accepted.
// Reset clears the byte count, the output register and the configuration
// (node address 0, sync byte 0x05). Write cfg only while idle.
module register_datagram_codec_unit #(
	parameter int unsigned RESP_LEN = rdc_pkg::RESP_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rdc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_wdata,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// reg_addr[6:0], write_data[38:7], rx_byte[46:39], zero[47]
	input  logic [47:0]                   s_axis_tdata,
	// req_type[1:0]
	input  logic [1:0]                    s_axis_tuser,
	input  logic                          s_axis_tlast,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// tx_byte[7:0], read_data[39:8], status[41:40], zero[47:42]
	output logic [47:0]                   m_axis_tdata,
	// result_kind[0]
	output logic                          m_axis_tuser,
	output logic                          m_axis_tlast
);
	import rdc_pkg::*;

	localparam int unsigned AW = $clog2(RESP_LEN);
	localparam int unsigned CW = $clog2(RESP_LEN + 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TX_BYTE,
		ST_TX_WAIT,
		ST_TX_CRC,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_FR_RD,
		ST_FR_CRC,
		ST_FR_WAIT,
		ST_VERDICT
	} state_t;

	state_t      state_q;
	logic [7:0]  node_addr_q;
	logic [7:0]  sync_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] len_q;
	logic [CW-1:0] idx_q;
	logic [AW-1:0] addr_q;
	logic [7:0]  prev_q;
	logic [2:0]  pos_q;
	logic [2:0]  last_pos_q;
	logic        wr_q;
	logic [6:0]  reg_q;
	logic [31:0] data_q;
	logic [1:0]  stat_q;

	logic        out_valid_q;
	logic        out_kind_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;
	logic [31:0] out_data_q;
	logic [1:0]  out_stat_q;

	logic        s_fire;
	logic        out_free;
	logic        out_load;
	logic        room;
	logic [CW-1:0] len_new;
	logic [7:0]  rdata;
	logic        ram_we;
	logic [7:0]  tx_byte;
	logic        match;
	logic        crc_busy;
	logic [7:0]  crc_val;
	crc_cmd_t    crc_cmd;

	logic [6:0]  in_reg;
	logic [31:0] in_wdata;
	logic [7:0]  in_rxb;

	assign in_reg   = s_axis_tdata[6:0];
	assign in_wdata = s_axis_tdata[38:7];
	assign in_rxb   = s_axis_tdata[46:39];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign out_load      = out_free && ((state_q == ST_TX_BYTE) ||
		(state_q == ST_TX_CRC) || (state_q == ST_VERDICT));
	assign room          = (cnt_q < CW'(RESP_LEN));
	assign len_new       = room ? (cnt_q + CW'(1)) : cnt_q;
	assign ram_we        = s_fire && (s_axis_tuser == REQ_RESP) && room;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {6'd0, out_stat_q, out_data_q, out_byte_q};

	always_comb begin
		case (pos_q)
			3'd0:    tx_byte = sync_q;
			3'd1:    tx_byte = node_addr_q;
			3'd2:    tx_byte = {wr_q, reg_q} | (wr_q ? WR_FLAG : 8'h00);
			default: tx_byte = data_q[31:24];
		endcase
	end

	// sync followed by 0xFF; the scan bound already leaves room for a frame
	assign match = (idx_q != CW'(0)) && (prev_q == sync_q) && (rdata == RESP_MARK);

	always_comb begin
		crc_cmd.clr = 1'b0;
		crc_cmd.ld  = 1'b0;
		crc_cmd.din = rdata;
		unique case (state_q)
			ST_IDLE: begin
				crc_cmd.clr = s_fire && ((s_axis_tuser == REQ_WRITE) ||
					(s_axis_tuser == REQ_READ));
			end
			ST_TX_BYTE: begin
				crc_cmd.ld  = out_free;
				crc_cmd.din = tx_byte;
			end
			ST_SCAN_CHK: begin
				crc_cmd.clr = match;
			end
			ST_FR_CRC: begin
				crc_cmd.ld = (pos_q != 3'(FRAME_LEN - 1));
			end
			default: begin
			end
		endcase
	end

	rdc_crc8 u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (crc_cmd),
		.crc    (crc_val),
		.busy   (crc_busy)
	);

	rdc_ram #(
		.WIDTH (8),
		.DEPTH (RESP_LEN)
	) u_rx_buf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (in_rxb),
		.raddr (addr_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			node_addr_q <= NODE_ADDR_RST;
			sync_q      <= SYNC_RST;
			cnt_q       <= '0;
			len_q       <= '0;
			idx_q       <= '0;
			addr_q      <= '0;
			prev_q      <= 8'h00;
			pos_q       <= 3'd0;
			last_pos_q  <= 3'd0;
			wr_q        <= 1'b0;
			reg_q       <= 7'd0;
			data_q      <= 32'd0;
			stat_q      <= STAT_OK;
			out_valid_q <= 1'b0;
			out_kind_q  <= KIND_BYTE;
			out_byte_q  <= 8'h00;
			out_last_q  <= 1'b0;
			out_data_q  <= 32'd0;
			out_stat_q  <= STAT_OK;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_NODE_ADDR) begin
					node_addr_q <= cfg_wdata;
				end else if (cfg_index == REG_SYNC) begin
					sync_q <= cfg_wdata;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						case (s_axis_tuser) inside
							REQ_WRITE, REQ_READ: begin
								wr_q       <= (s_axis_tuser == REQ_WRITE);
								reg_q      <= in_reg;
								data_q     <= in_wdata;
								pos_q      <= 3'd0;
								last_pos_q <= (s_axis_tuser == REQ_WRITE) ?
									3'(WR_LEN - 1) : 3'(RD_LEN - 1);
								state_q    <= ST_TX_BYTE;
							end
							REQ_RESP: begin
								if (!s_axis_tlast) begin
									cnt_q <= len_new;
								end else begin
									cnt_q  <= '0;
									len_q  <= len_new;
									idx_q  <= '0;
									addr_q <= '0;
									data_q <= 32'd0;
									if (len_new < CW'(FRAME_LEN)) begin
										stat_q  <= STAT_SHORT;
										state_q <= ST_VERDICT;
									end else begin
										state_q <= ST_SCAN_RD;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_TX_BYTE: begin
					if (out_free) begin
						out_kind_q  <= KIND_BYTE;
						out_byte_q  <= tx_byte;
						out_last_q  <= 1'b0;
						out_data_q  <= 32'd0;
						out_stat_q  <= STAT_OK;
						if (pos_q >= 3'd3) begin
							data_q <= {data_q[23:0], 8'h00};
						end
						pos_q   <= pos_q + 3'd1;
						state_q <= ST_TX_WAIT;
					end
				end
				ST_TX_WAIT: begin
					if (!crc_busy) begin
						state_q <= (pos_q == last_pos_q) ? ST_TX_CRC : ST_TX_BYTE;
					end
				end
				ST_TX_CRC: begin
					if (out_free) begin
						out_kind_q  <= KIND_BYTE;
						out_byte_q  <= crc_val;
						out_last_q  <= 1'b1;
						out_data_q  <= 32'd0;
						out_stat_q  <= STAT_OK;
						state_q     <= ST_IDLE;
					end
				end
				ST_SCAN_RD: begin
					state_q <= ST_SCAN_CHK;
				end
				ST_SCAN_CHK: begin
					if (match) begin
						addr_q  <= AW'(idx_q - CW'(1));
						pos_q   <= 3'd0;
						state_q <= ST_FR_RD;
					end else if (({1'b0, idx_q} + (CW+1)'(FRAME_LEN)) > {1'b0, len_q}) begin
						stat_q  <= STAT_NO_FRAME;
						state_q <= ST_VERDICT;
					end else begin
						prev_q  <= rdata;
						idx_q   <= idx_q + CW'(1);
						addr_q  <= AW'(idx_q + CW'(1));
						state_q <= ST_SCAN_RD;
					end
				end
				ST_FR_RD: begin
					state_q <= ST_FR_CRC;
				end
				ST_FR_CRC: begin
					if (pos_q == 3'(FRAME_LEN - 1)) begin
						// rdata is the received CRC byte here
						stat_q  <= (rdata == crc_val) ? STAT_OK : STAT_CRC_BAD;
						state_q <= ST_VERDICT;
					end else begin
						data_q  <= {data_q[23:0], rdata};
						pos_q   <= pos_q + 3'd1;
						addr_q  <= addr_q + AW'(1);
						state_q <= ST_FR_WAIT;
					end
				end
				ST_FR_WAIT: begin
					if (!crc_busy) begin
						state_q <= ST_FR_CRC;
					end
				end
				ST_VERDICT: begin
					if (out_free) begin
						out_kind_q  <= KIND_VERDICT;
						out_byte_q  <= 8'h00;
						out_last_q  <= 1'b0;
						out_data_q  <= (stat_q == STAT_OK) ? data_q : 32'd0;
						out_stat_q  <= stat_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_cnt_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && (s_axis_tuser == REQ_RESP) && s_axis_tlast |=> (cnt_q == '0))
		else $error("byte count not cleared after last response byte");

	a_crc_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		crc_cmd.ld |-> !crc_busy)
		else $error("CRC unit loaded while shifting");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		crc_busy |-> !s_axis_tready)
		else $error("input accepted while CRC unit busy");

endmodule

/* rtl/rdc_ram.sv */
// Generic single-port-write RAM with registered read.
module rdc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* rtl/rdc_crc8.sv */
// Bit-serial CRC-8 (poly 0x07), one data bit per cycle, LSB first.
module rdc_crc8 (
	input  logic              clk,
	input  logic              arst_n,
	input  rdc_pkg::crc_cmd_t cmd,
	output logic [7:0]        crc,
	output logic              busy
);
	import rdc_pkg::*;

	logic [7:0] crc_q;
	logic [7:0] sh_q;
	logic [3:0] bit_q;
	logic       fb;

	assign fb   = crc_q[7] ^ (sh_q[0] & LSB_MASK[0]);
	assign crc  = crc_q;
	assign busy = (bit_q != 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= 8'h00;
			sh_q  <= 8'h00;
			bit_q <= 4'd0;
		end else begin
			if (cmd.clr) begin
				crc_q <= 8'h00;
			end else if (busy) begin
				crc_q <= {crc_q[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
			end
			if (cmd.ld) begin
				sh_q  <= cmd.din;
				bit_q <= 4'd8;
			end else if (busy) begin
				sh_q  <= {1'b0, sh_q[7:1]};
				bit_q <= bit_q - 4'd1;
			end
		end
	end
endmodule
